FILE: design/assert_macros.svh
// Assertion helpers. Every use expects signals named clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rspb_pkg.sv
package rspb_pkg;

	localparam int COORD_W    = 12;
	localparam int CHAN_W     = 8;
	localparam int Q16_W      = 16;
	localparam int MASK_W     = 17;
	localparam int VAL_W      = 28;
	localparam int ROOT_W     = 17;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int CFG_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CNT_W      = 3;

	localparam int DEF_MAX_SPOTS  = 4;
	localparam int DEF_COORD_BITS = 12;

	// Mask lane depth: deltas, squares, sum, one stage per root bit, classify,
	// one stage per quotient bit, final select.
	localparam int MASK_LAT = 3 + ROOT_W + 1 + Q16_W + 1;

	localparam logic [Q16_W-1:0]  DARKNESS_RESET   = 16'd19661;
	localparam logic [Q16_W-1:0]  SEVEN_TENTHS_Q16 = 16'd45875;
	localparam logic [MASK_W-1:0] ONE_Q16          = 17'h10000;
	localparam logic [MASK_W-1:0] HALF_Q16         = 17'h08000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPOT_COUNT = 3'd0,
		REG_DARKNESS   = 3'd1,
		REG_SPOT_ZERO  = 3'd2,
		REG_SPOT_ONE   = 3'd3,
		REG_SPOT_TWO   = 3'd4,
		REG_SPOT_THREE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [Q16_W-1:0]   rad;
		logic [Q16_W-1:0]   inten;
		logic [Q16_W-1:0]   inner;
		logic [Q16_W-1:0]   den;
	} spot_t;

	typedef logic [2:0][CHAN_W-1:0] rgb_t;
	typedef logic [2:0][VAL_W-1:0]  val_t;

endpackage

FILE: design/rspb_pix_in_if.sv
interface rspb_pix_in_if;
	logic                           valid;
	logic                           ready;
	logic [rspb_pkg::COORD_W-1:0]   pixel_x;
	logic [rspb_pkg::COORD_W-1:0]   pixel_y;
	logic [rspb_pkg::CHAN_W-1:0]    red_in;
	logic [rspb_pkg::CHAN_W-1:0]    green_in;
	logic [rspb_pkg::CHAN_W-1:0]    blue_in;

	modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in, input ready);
	modport sink (input valid, pixel_x, pixel_y, red_in, green_in, blue_in, output ready);
endinterface

FILE: design/rspb_pix_out_if.sv
interface rspb_pix_out_if;
	logic                        valid;
	logic                        ready;
	logic [rspb_pkg::CHAN_W-1:0] red_out;
	logic [rspb_pkg::CHAN_W-1:0] green_out;
	logic [rspb_pkg::CHAN_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: design/rspb_cfg.sv
module rspb_cfg #(
	parameter int MAX_SPOTS = rspb_pkg::DEF_MAX_SPOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [rspb_pkg::CFG_IDX_W-1:0]    idx,
	input  logic [rspb_pkg::CFG_DATA_W-1:0]   data,
	output logic [rspb_pkg::CNT_W-1:0]        spot_count,
	output logic [rspb_pkg::Q16_W-1:0]        darkness,
	output rspb_pkg::spot_t [MAX_SPOTS-1:0]   spots
);

	logic [rspb_pkg::CNT_W-1:0] count_q;
	logic [rspb_pkg::Q16_W-1:0] dark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dark_q  <= rspb_pkg::DARKNESS_RESET;
		end else if (we) begin
			case (rspb_pkg::reg_idx_t'(idx))
				rspb_pkg::REG_SPOT_COUNT: count_q <= data[rspb_pkg::CNT_W-1:0];
				rspb_pkg::REG_DARKNESS:   dark_q  <= data[rspb_pkg::Q16_W-1:0];
				default: ;
			endcase
		end
	end

	assign spot_count = count_q;
	assign darkness   = dark_q;

	for (genvar k = 0; k < MAX_SPOTS; k++) begin : g_spot
		logic [rspb_pkg::COORD_W-1:0] cx_q, cy_q;
		logic [rspb_pkg::Q16_W-1:0]   rad_q, inten_q, inner_q, den_q;
		logic [32:0]                  inner_prod;
		logic                         hit;

		assign hit = we && (idx == rspb_pkg::CFG_IDX_W'(int'(rspb_pkg::REG_SPOT_ZERO) + k));
		assign inner_prod = 33'(rad_q) * 33'(rspb_pkg::SEVEN_TENTHS_Q16)
			+ 33'(rspb_pkg::HALF_Q16);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cx_q    <= '0;
				cy_q    <= '0;
				rad_q   <= '0;
				inten_q <= '0;
				inner_q <= '0;
				den_q   <= '0;
			end else begin
				if (hit) begin
					cx_q    <= data[11:0];
					cy_q    <= data[23:12];
					rad_q   <= data[39:24];
					inten_q <= data[55:40];
				end
				// The derived radii follow a write: inner_q is registered from rad_q, and den_q from rad_q and inner_q.
				inner_q <= inner_prod[31:16];
				den_q   <= rad_q - inner_q;
			end
		end

		assign spots[k] = '{cx: cx_q, cy: cy_q, rad: rad_q, inten: inten_q,
			inner: inner_q, den: den_q};
	end

endmodule

FILE: design/rspb_mask.sv
module rspb_mask #(
	parameter int COORD_BITS = rspb_pkg::DEF_COORD_BITS
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [rspb_pkg::COORD_W-1:0]    px,
	input  logic [rspb_pkg::COORD_W-1:0]    py,
	input  rspb_pkg::spot_t                 spot,
	output logic [rspb_pkg::MASK_W-1:0]     mask
);

	localparam int CW   = rspb_pkg::COORD_W;
	localparam int RW   = rspb_pkg::ROOT_W;
	localparam int NW   = rspb_pkg::RAD_W;
	localparam int QW   = rspb_pkg::Q16_W;
	localparam logic [CW-1:0] CMASK =
		(COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);

	logic [CW-1:0]   pxm, pym, cxm, cym, dx, dy;
	logic [CW-1:0]   dx_s1, dy_s1;
	logic [2*CW-1:0] sqx_s2, sqy_s2;
	logic [2*CW:0]   d2;
	logic [NW-1:0]   sq_rem_s  [0:RW-1];
	logic [RW-1:0]   sq_root_s [1:RW];
	logic [QW-1:0]   dval;
	logic            in_core, outside;
	logic [QW-1:0]   dv_rem_s  [0:QW-1];
	logic [QW-1:0]   dv_q_s    [1:QW];
	logic            fl_in_s   [0:QW];
	logic            fl_mid_s  [0:QW];
	logic [rspb_pkg::MASK_W-1:0] mask_s;

	assign pxm = px & CMASK;
	assign pym = py & CMASK;
	assign cxm = spot.cx & CMASK;
	assign cym = spot.cy & CMASK;
	assign dx  = (pxm >= cxm) ? pxm - cxm : cxm - pxm;
	assign dy  = (pym >= cym) ? pym - cym : cym - pym;
	assign d2  = (2*CW+1)'(sqx_s2) + (2*CW+1)'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1       <= dx;
			dy_s1       <= dy;
			sqx_s2      <= dx_s1 * dx_s1;
			sqy_s2      <= dy_s1 * dy_s1;
			sq_rem_s[0] <= NW'({d2, 8'd0});
		end
	end

	// Integer square root, one result bit per stage, most significant first.
	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		localparam int B = RW - 1 - j;
		logic [RW-1:0] root_i;
		logic [NW:0]   trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign root_i = '0;
		end else begin : g_rest
			assign root_i = sq_root_s[j];
		end

		assign trial = ((NW+1)'(root_i) << (B + 1)) | ((NW+1)'(1) << (2 * B));
		assign ge    = {1'b0, sq_rem_s[j]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_root_s[j+1] <= ge ? (root_i | (RW'(1) << B)) : root_i;
			end
		end

		if (j < RW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					sq_rem_s[j+1] <= ge ? NW'({1'b0, sq_rem_s[j]} - trial) : sq_rem_s[j];
				end
			end
		end
	end

	assign dval    = sq_root_s[RW][RW-1] ? {QW{1'b1}} : sq_root_s[RW][QW-1:0];
	assign in_core = dval <= spot.inner;
	assign outside = dval > spot.rad;

	always_ff @(posedge clk) begin
		if (en) begin
			fl_in_s[0]  <= in_core;
			fl_mid_s[0] <= !in_core && !outside;
			dv_rem_s[0] <= (!in_core && !outside) ? spot.rad - dval : '0;
		end
	end

	// Restoring division of (rad - d) << 16 by (rad - inner). The dividend
	// stays below the divisor, so every quotient bit fits in sixteen steps.
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [QW:0]   r2;
		logic          ge;
		logic [QW-1:0] q_i;

		if (k == 0) begin : g_first
			assign q_i = '0;
		end else begin : g_rest
			assign q_i = dv_q_s[k];
		end

		assign r2 = {dv_rem_s[k], 1'b0};
		assign ge = r2 >= {1'b0, spot.den};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_q_s[k+1]   <= {q_i[QW-2:0], ge};
				fl_in_s[k+1]  <= fl_in_s[k];
				fl_mid_s[k+1] <= fl_mid_s[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k+1] <= ge ? QW'(r2 - {1'b0, spot.den}) : r2[QW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s <= fl_in_s[QW] ? rspb_pkg::ONE_Q16 :
				fl_mid_s[QW] ? {1'b0, dv_q_s[QW]} : '0;
		end
	end

	assign mask = mask_s;

endmodule

FILE: design/rspb_blend.sv
module rspb_blend #(
	parameter int MAX_SPOTS = rspb_pkg::DEF_MAX_SPOTS
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  rspb_pkg::rgb_t                            pix,
	input  logic [MAX_SPOTS-1:0][rspb_pkg::MASK_W-1:0] masks,
	input  logic [MAX_SPOTS-1:0][rspb_pkg::Q16_W-1:0]  inten,
	input  logic [rspb_pkg::Q16_W-1:0]                darkness,
	input  logic [rspb_pkg::CNT_W-1:0]                spot_count,
	output rspb_pkg::rgb_t                            res
);

	localparam int VW    = rspb_pkg::VAL_W;
	localparam int MW    = rspb_pkg::MASK_W;
	localparam int PW    = VW + MW;
	localparam int CARRY = (MAX_SPOTS > 1) ? MAX_SPOTS - 1 : 1;

	typedef logic [MAX_SPOTS-1:0][MW-1:0] msk_t;
	typedef logic [2:0][PW-1:0]           prod_t;

	logic [rspb_pkg::CNT_W-1:0] cnt_eff;
	rspb_pkg::rgb_t             pix_c [0:CARRY-1];
	msk_t                       mk_c  [0:CARRY-1];
	rspb_pkg::val_t             v_c   [0:MAX_SPOTS-1];
	rspb_pkg::rgb_t             out_s;

	assign cnt_eff = (spot_count > rspb_pkg::CNT_W'(MAX_SPOTS)) ?
		rspb_pkg::CNT_W'(MAX_SPOTS) : spot_count;

	// Three stages per spot: brightness products, blend products, rounding sum.
	for (genvar s = 0; s < MAX_SPOTS; s++) begin : g_spot
		rspb_pkg::rgb_t pix_i, pix_a, pix_b;
		msk_t           mk_i, mk_a, mk_b;
		rspb_pkg::val_t v_i, va_a, br_a;
		prod_t          p1_b, p2_b;
		logic [MW-1:0]  mf;

		if (s == 0) begin : g_first
			assign pix_i = pix;
			assign mk_i  = masks;
			for (genvar c = 0; c < 3; c++) begin : g_dark
				assign v_i[c] = VW'(pix[c]) * VW'(darkness);
			end
		end else begin : g_rest
			assign pix_i = pix_c[s-1];
			assign mk_i  = mk_c[s-1];
			assign v_i   = v_c[s-1];
		end

		// A disabled spot blends with a zero mask, which leaves the value as is.
		assign mf = (rspb_pkg::CNT_W'(s) < cnt_eff) ? mk_a[s] : '0;

		always_ff @(posedge clk) begin
			if (en) begin
				pix_a <= pix_i;
				mk_a  <= mk_i;
				va_a  <= v_i;
				pix_b <= pix_a;
				mk_b  <= mk_a;
				for (int c = 0; c < 3; c++) begin
					br_a[c]   <= VW'({24'(pix_i[c]) * 24'(inten[s]), 4'd0});
					p1_b[c]   <= PW'(va_a[c]) * PW'(rspb_pkg::ONE_Q16 - mf);
					p2_b[c]   <= PW'(br_a[c]) * PW'(mf);
					v_c[s][c] <= VW'(((PW+1)'(p1_b[c]) + (PW+1)'(p2_b[c])
						+ (PW+1)'(rspb_pkg::HALF_Q16)) >> 16);
				end
			end
		end

		if (s < MAX_SPOTS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					pix_c[s] <= pix_b;
					mk_c[s]  <= mk_b;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				logic [VW-16:0] o;
				o = (VW-15)'((VW'(v_c[MAX_SPOTS-1][c]) + VW'(rspb_pkg::HALF_Q16)) >> 16);
				out_s[c] <= (o > (VW-15)'(255)) ? 8'hFF : o[7:0];
			end
		end
	end

	assign res = out_s;

endmodule

FILE: design/radial_spotlight_pixel_blend.sv
// Radial spotlight blend: one RGB pixel with its x,y position in, one pixel out
// per beat. Each channel starts at darkness times its value, then each enabled
// spotlight in index order mixes in intensity times the value under a radial
// mask (full inside 0.7 of the radius, linear falloff to zero at the radius),
// and the result is rounded and saturated to 0..255. A new pixel is taken every
// clock while the skid entry is empty; the depth is set by the distance square
// root and the falloff divider, each unrolled one bit per stage, and three
// stages per spot of blend multipliers. Spot lanes run in parallel. An output
// register plus one skid entry hold finished pixels; the input stalls only
// when both are full. The user must write registers through
// cfg_we/cfg_index/cfg_data while no pixel is in flight; the block does not
// enforce it. The inner radius is registered from the radius after a spot write.
module radial_spotlight_pixel_blend #(
	parameter int MAX_SPOTS  = rspb_pkg::DEF_MAX_SPOTS,
	parameter int COORD_BITS = rspb_pkg::DEF_COORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rspb_pix_in_if.sink                     pixel_in,
	rspb_pix_out_if.source                  pixel_out,
	input  logic                            cfg_we,
	input  logic [rspb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rspb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ML  = rspb_pkg::MASK_LAT;
	localparam int LAT = ML + 3 * MAX_SPOTS + 1;

	logic                                       en;
	logic                                       vld_s [1:LAT];
	rspb_pkg::rgb_t                             pix_s [1:ML];
	logic [rspb_pkg::CNT_W-1:0]                 spot_count;
	logic [rspb_pkg::Q16_W-1:0]                 darkness;
	rspb_pkg::spot_t [MAX_SPOTS-1:0]            spots;
	logic [MAX_SPOTS-1:0][rspb_pkg::MASK_W-1:0] masks;
	logic [MAX_SPOTS-1:0][rspb_pkg::Q16_W-1:0]  inten;
	rspb_pkg::rgb_t                             res;
	logic                                       out_vld_q, skid_vld_q, pop, push;
	rspb_pkg::rgb_t                             out_q, skid_q;

	assign en             = !skid_vld_q;
	assign pixel_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= pixel_in.valid;
			for (int k = 2; k <= LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s[1] <= {pixel_in.blue_in, pixel_in.green_in, pixel_in.red_in};
			for (int k = 2; k <= ML; k++) begin
				pix_s[k] <= pix_s[k-1];
			end
		end
	end

	rspb_cfg #(.MAX_SPOTS(MAX_SPOTS)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.we         (cfg_we),
		.idx        (cfg_index),
		.data       (cfg_data),
		.spot_count (spot_count),
		.darkness   (darkness),
		.spots      (spots)
	);

	for (genvar k = 0; k < MAX_SPOTS; k++) begin : g_lane
		rspb_mask #(.COORD_BITS(COORD_BITS)) u_mask (
			.clk  (clk),
			.en   (en),
			.px   (pixel_in.pixel_x),
			.py   (pixel_in.pixel_y),
			.spot (spots[k]),
			.mask (masks[k])
		);
		assign inten[k] = spots[k].inten;
	end

	rspb_blend #(.MAX_SPOTS(MAX_SPOTS)) u_blend (
		.clk        (clk),
		.en         (en),
		.pix        (pix_s[ML]),
		.masks      (masks),
		.inten      (inten),
		.darkness   (darkness),
		.spot_count (spot_count),
		.res        (res)
	);

	assign pop  = out_vld_q && pixel_out.ready;
	assign push = vld_s[LAT] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign pixel_out.valid     = out_vld_q;
	assign pixel_out.red_out   = out_q[0];
	assign pixel_out.green_out = out_q[1];
	assign pixel_out.blue_out  = out_q[2];

endmodule

FILE: design/rspb_checker.sv
`include "assert_macros.svh"

module rspb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] out_data
);

	// Pixels accepted at the input and not yet delivered at the output.
	logic [7:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
		end
	end

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped while stalled")
	`ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled output changed")
	`ASSERT_IMP(a_no_phantom, cnt_q == 8'd0, !out_valid, "output beat with no pixel in flight")
	`ASSERT_HOLDS(a_stall_cause, in_ready || out_valid, "input stalled with empty output")

endmodule

bind radial_spotlight_pixel_blend rspb_checker u_rspb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_in.valid),
	.in_ready  (pixel_in.ready),
	.out_valid (pixel_out.valid),
	.out_ready (pixel_out.ready),
	.out_data  ({pixel_out.blue_out, pixel_out.green_out, pixel_out.red_out})
);
